// ===== sv/assert_macros.svh =====
// Assertion macros used by the port level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, skipped while reset is high.
`define BHA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error(msg);

// Checked on every rising edge, reset included.
`define BHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
   else $error(msg);

`endif

// ===== sv/bha_pkg.sv =====
// Types, constants and helper functions of the beat histogram accumulator.
package bha_pkg;

   localparam int NUM_BINS      = 128;
   localparam int LAG_MAX       = 512;
   localparam int MIN_TEMPO_BIN = 40;

   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int EE_W  = BIN_W + 1;
   localparam int DVD_W = 33 + BIN_W;
   localparam int DVS_W = (BIN_W + 1 > 10) ? BIN_W + 1 : 10;
   localparam int NUM_W = DVD_W + 1;

   localparam logic [31:0] BPM_SCALE_RESET = 32'd15360;
   localparam logic [7:0]  END_BIN_RESET   = 8'd100;

   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic CSR_BPM_SCALE = 1'b0;
   localparam logic CSR_END_BIN   = 1'b1;

   typedef struct packed {
      logic [1:0]         req_type;
      logic               frame_start;
      logic [8:0]         lag;
      logic signed [15:0] amp;
      logic [6:0]         read_index;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0] bin_value;
      logic [6:0]         bin_index;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_READ_OUT,
      ST_BIN_DIV,
      ST_MEAN_START,
      ST_MEAN_DIV,
      ST_LO_RD,
      ST_HI_RD,
      ST_HI_WAIT,
      ST_INT_START,
      ST_INT_DIV,
      ST_ADVANCE
   } state_type;

   typedef enum logic [1:0] {
      DIV_BIN,
      DIV_MEAN,
      DIV_INTERP
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        restart;
      logic        clear;
      logic        rd_index;
      logic        rsp_load;
      logic        div_start;
      div_sel_type div_sel;
      logic        acc;
      logic        rd_prev;
      logic        mean_wr;
      logic        rd_pprev;
      logic        latch_lo;
      logic        latch_hi;
      logic        int_start;
      logic        int_wr;
      logic        advance;
   } cmd_type;

   typedef struct packed {
      logic [1:0] in_type;
      logic       in_fs;
      logic       in_lag_ok;
      logic       div_busy;
      logic       bin_ok;
      logic       same_bin;
      logic       need_interp;
      logic       k_last;
      logic       rsp_ready;
   } status_type;

   // Effective end bin: end_bin limited to the number of bins.
   function automatic logic [EE_W-1:0] eff_end_f(input logic [7:0] e);
      if (32'(e) < 32'(NUM_BINS)) begin
         return EE_W'(e);
      end
      return EE_W'(NUM_BINS);
   endfunction

   function automatic logic signed [31:0] sat32_f(input logic signed [35:0] v);
      logic signed [35:0] hi_lim;
      logic signed [35:0] lo_lim;
      hi_lim = 36'sd2147483647;
      lo_lim = -36'sd2147483648;
      if (v > hi_lim) begin
         return 32'sh7FFFFFFF;
      end
      if (v < lo_lim) begin
         return 32'sh80000000;
      end
      return $signed(v[31:0]);
   endfunction

endpackage

// ===== sv/bha_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module bha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/bha_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module bha_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bha_pkg::DVD_W-1:0] dividend,
   input  logic [bha_pkg::DVS_W-1:0] divisor,
   output logic                      busy,
   output logic [bha_pkg::DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(bha_pkg::DVD_W + 1);

   logic                      busy_ff, busy_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [bha_pkg::DVD_W-1:0] quo_ff, quo_in;
   logic [bha_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [bha_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [bha_pkg::DVS_W:0]   trial;
   logic [bha_pkg::DVS_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[bha_pkg::DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(bha_pkg::DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[bha_pkg::DVS_W-1:0];
            quo_in = {quo_ff[bha_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[bha_pkg::DVS_W-1:0];
            quo_in = {quo_ff[bha_pkg::DVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/bha_datapath.sv =====
// Datapath: configuration, run state, histogram memory, divider and result register.
module bha_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata,
   input  bha_pkg::req_beat_type req_data,
   input  bha_pkg::cmd_type      cmd,
   output bha_pkg::status_type   status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bha_pkg::rsp_beat_type rsp_data
);

   localparam int BW = bha_pkg::BIN_W;
   localparam int EW = bha_pkg::EE_W;
   localparam int NW = bha_pkg::NUM_W;
   localparam int QW = bha_pkg::DVD_W;
   localparam int SW = bha_pkg::DVS_W;

   logic [31:0]           bpm_scale_ff;
   logic [7:0]            end_bin_ff;
   logic signed [15:0]    amp_ff;
   logic [6:0]            ridx_ff;
   logic                  in_range_ff;
   logic signed [31:0]    run_sum_ff;
   logic [9:0]            run_count_ff;
   logic [BW-1:0]         prev_ff, pprev_ff, b_ff, k_ff;
   logic signed [31:0]    lo_ff, hi_ff;
   logic signed [NW-1:0]  numer_ff;
   logic                  neg_ff;
   logic [bha_pkg::NUM_BINS-1:0] valid_ff;
   logic                  rd_valid_ff;
   logic                  rsp_valid_ff;
   bha_pkg::rsp_beat_type rsp_data_ff;

   logic [EW-1:0]         eff_end;
   logic [BW-1:0]         restart_bin;
   logic [9:0]            lag_p1;
   logic [32:0]           bin_num;
   logic [32:0]           rs_ext, rs_mag;
   logic signed [32:0]    diff;
   logic signed [NW-1:0]  numer_in;
   logic [NW-1:0]         numer_mag;
   logic [QW-1:0]         dvd;
   logic [SW-1:0]         dvs;
   logic                  div_busy;
   logic [QW-1:0]         quo;
   logic                  re, we;
   logic [BW-1:0]         raddr, waddr;
   logic [31:0]           wdata;
   logic [31:0]           rdata;
   logic signed [31:0]    hist_val;
   logic signed [35:0]    mq, iq;
   logic signed [31:0]    mean_sum, int_val, acc_sum;

   always_comb begin
      eff_end     = bha_pkg::eff_end_f(end_bin_ff);
      restart_bin = (eff_end != '0) ? BW'(eff_end - EW'(1)) : '0;
      lag_p1      = {1'b0, req_data.lag} + 10'd1;
      bin_num     = 33'(bpm_scale_ff) + (33'(lag_p1) << 7);
      rs_ext      = {run_sum_ff[31], run_sum_ff};
      rs_mag      = run_sum_ff[31] ? (33'd0 - rs_ext) : rs_ext;
      diff        = $signed({hi_ff[31], hi_ff}) - $signed({lo_ff[31], lo_ff});
      numer_in    = numer_ff + $signed({{(NW-33){diff[32]}}, diff});
      numer_mag   = numer_in[NW-1] ? (NW'(0) - NW'(numer_in)) : NW'(numer_in);
      hist_val    = rd_valid_ff ? $signed(rdata) : 32'sd0;

      unique case (cmd.div_sel)
         bha_pkg::DIV_BIN: begin
            dvd = QW'(bin_num[32:8]);
            dvs = SW'(lag_p1);
         end
         bha_pkg::DIV_MEAN: begin
            dvd = QW'(rs_mag);
            dvs = SW'(run_count_ff);
         end
         default: begin
            dvd = numer_mag[QW-1:0];
            dvs = SW'(pprev_ff) - SW'(prev_ff) + SW'(1);
         end
      endcase

      // Quotients carry their sign separately and truncate toward zero.
      mq = $signed({4'b0, quo[31:0]});
      if (run_sum_ff[31]) begin
         mq = -mq;
      end
      iq = $signed({3'b0, quo[32:0]});
      if (neg_ff) begin
         iq = -iq;
      end
      mean_sum = bha_pkg::sat32_f($signed({{4{hist_val[31]}}, hist_val}) + mq);
      int_val  = bha_pkg::sat32_f($signed({{4{lo_ff[31]}}, lo_ff}) + iq);
      acc_sum  = bha_pkg::sat32_f($signed({{4{run_sum_ff[31]}}, run_sum_ff})
                                  + $signed({{20{amp_ff[15]}}, amp_ff}));

      re = cmd.rd_index | cmd.rd_prev | cmd.rd_pprev;
      priority if (cmd.rd_index) begin
         raddr = BW'(req_data.read_index);
      end else if (cmd.rd_prev) begin
         raddr = prev_ff;
      end else begin
         raddr = pprev_ff;
      end

      we = cmd.mean_wr | cmd.int_wr;
      if (cmd.mean_wr) begin
         waddr = prev_ff;
         wdata = mean_sum;
      end else begin
         waddr = k_ff;
         wdata = int_val;
      end

      status.in_type     = req_data.req_type;
      status.in_fs       = req_data.frame_start;
      status.in_lag_ok   = (32'(req_data.lag) != 32'd0)
                           && (32'(req_data.lag) < 32'(bha_pkg::LAG_MAX));
      status.div_busy    = div_busy;
      status.bin_ok      = (quo > QW'(bha_pkg::MIN_TEMPO_BIN)) && (quo < QW'(eff_end));
      status.same_bin    = (prev_ff == BW'(quo));
      status.need_interp = (EW'(pprev_ff) > EW'(prev_ff) + EW'(1));
      status.k_last      = (EW'(k_ff) + EW'(1) == EW'(pprev_ff));
      status.rsp_ready   = !rsp_valid_ff || !rsp_stall;
   end

   bha_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .busy     (div_busy),
      .quotient (quo)
   );

   bha_ram #(
      .WIDTH (32),
      .DEPTH (bha_pkg::NUM_BINS)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bpm_scale_ff <= bha_pkg::BPM_SCALE_RESET;
         end_bin_ff   <= bha_pkg::END_BIN_RESET;
         prev_ff      <= BW'(bha_pkg::eff_end_f(bha_pkg::END_BIN_RESET) - EW'(1));
         pprev_ff     <= BW'(bha_pkg::eff_end_f(bha_pkg::END_BIN_RESET) - EW'(1));
         run_sum_ff   <= '0;
         run_count_ff <= 10'd1;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               bha_pkg::CSR_BPM_SCALE: bpm_scale_ff <= csr_wdata;
               bha_pkg::CSR_END_BIN:   end_bin_ff   <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (cmd.restart) begin
            prev_ff      <= restart_bin;
            pprev_ff     <= restart_bin;
            run_sum_ff   <= '0;
            run_count_ff <= 10'd1;
         end
         if (cmd.acc) begin
            run_sum_ff <= acc_sum;
            if (status.same_bin && run_count_ff != 10'd1023) begin
               run_count_ff <= run_count_ff + 10'd1;
            end
         end
         if (cmd.mean_wr) begin
            run_sum_ff   <= '0;
            run_count_ff <= 10'd1;
         end
         if (cmd.advance) begin
            pprev_ff <= prev_ff;
            prev_ff  <= b_ff;
         end
         if (cmd.clear) begin
            valid_ff <= '0;
         end else if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (cmd.load) begin
         amp_ff      <= req_data.amp;
         ridx_ff     <= req_data.read_index;
         in_range_ff <= (32'(req_data.read_index) < 32'(bha_pkg::NUM_BINS));
      end
      if (re) begin
         rd_valid_ff <= valid_ff[raddr];
      end
      if (cmd.acc) begin
         b_ff <= BW'(quo);
      end
      if (cmd.latch_lo) begin
         lo_ff <= hist_val;
      end
      if (cmd.latch_hi) begin
         hi_ff    <= hist_val;
         numer_ff <= '0;
         k_ff     <= prev_ff + BW'(1);
      end
      if (cmd.int_start) begin
         numer_ff <= numer_in;
         neg_ff   <= numer_in[NW-1];
      end
      if (cmd.int_wr) begin
         k_ff <= k_ff + BW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.bin_value <= in_range_ff ? hist_val : 32'sd0;
         rsp_data_ff.bin_index <= ridx_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/bha_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module bha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bha_pkg::status_type status,
   output bha_pkg::cmd_type    cmd
);

   bha_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bha_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         bha_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (status.in_type)
                  bha_pkg::REQ_SAMPLE: begin
                     cmd.restart = status.in_fs;
                     if (status.in_lag_ok) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = bha_pkg::DIV_BIN;
                        state_in      = bha_pkg::ST_BIN_DIV;
                     end
                  end
                  bha_pkg::REQ_READ: begin
                     cmd.rd_index = 1'b1;
                     state_in     = bha_pkg::ST_READ_WAIT;
                  end
                  bha_pkg::REQ_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         bha_pkg::ST_READ_WAIT: state_in = bha_pkg::ST_READ_OUT;
         bha_pkg::ST_READ_OUT: begin
            if (status.rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = bha_pkg::ST_IDLE;
            end
         end
         bha_pkg::ST_BIN_DIV: begin
            if (!status.div_busy) begin
               if (status.bin_ok) begin
                  cmd.acc  = 1'b1;
                  state_in = status.same_bin ? bha_pkg::ST_LO_RD : bha_pkg::ST_MEAN_START;
               end else begin
                  state_in = bha_pkg::ST_IDLE;
               end
            end
         end
         bha_pkg::ST_MEAN_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = bha_pkg::DIV_MEAN;
            cmd.rd_prev   = 1'b1;
            state_in      = bha_pkg::ST_MEAN_DIV;
         end
         bha_pkg::ST_MEAN_DIV: begin
            cmd.div_sel = bha_pkg::DIV_MEAN;
            if (!status.div_busy) begin
               cmd.mean_wr = 1'b1;
               state_in    = bha_pkg::ST_LO_RD;
            end
         end
         bha_pkg::ST_LO_RD: begin
            if (status.need_interp) begin
               cmd.rd_prev = 1'b1;
               state_in    = bha_pkg::ST_HI_RD;
            end else begin
               state_in = bha_pkg::ST_ADVANCE;
            end
         end
         bha_pkg::ST_HI_RD: begin
            cmd.latch_lo = 1'b1;
            cmd.rd_pprev = 1'b1;
            state_in     = bha_pkg::ST_HI_WAIT;
         end
         bha_pkg::ST_HI_WAIT: begin
            cmd.latch_hi = 1'b1;
            state_in     = bha_pkg::ST_INT_START;
         end
         bha_pkg::ST_INT_START: begin
            cmd.int_start = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = bha_pkg::DIV_INTERP;
            state_in      = bha_pkg::ST_INT_DIV;
         end
         bha_pkg::ST_INT_DIV: begin
            cmd.div_sel = bha_pkg::DIV_INTERP;
            if (!status.div_busy) begin
               cmd.int_wr = 1'b1;
               state_in   = status.k_last ? bha_pkg::ST_ADVANCE : bha_pkg::ST_INT_START;
            end
         end
         bha_pkg::ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = bha_pkg::ST_IDLE;
         end
         default: state_in = bha_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== sv/beat_histogram_accumulator.sv =====
// Top level of the beat histogram accumulator.
// One request beat is taken at a time and the input stalls until it is done. A clear beat,
// an unused request type and a sample with a lag out of range leave the block idle. A bin
// read passes the read wait and read out states and loads its result beat in read out.
// Any other sample goes through the shared divider, which makes one quotient bit per cycle.
// A sample whose tempo bin is out of range ends after the bin division; one in range is
// accumulated, and a changed bin then writes the mean of the previous one. Each skipped bin
// is interpolated with one division. The result register lets a read result wait for the
// consumer while later beats are taken. A later read waits in read out until that beat is taken.
module beat_histogram_accumulator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bha_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bha_pkg::rsp_beat_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata
);

   bha_pkg::cmd_type    cmd;
   bha_pkg::status_type status;

   bha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bha_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/bha_checker.sv =====
// Port level checker for the beat histogram accumulator, with its bind.
`include "assert_macros.svh"

module bha_port_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input bha_pkg::req_beat_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input bha_pkg::rsp_beat_type rsp_data
);

   `BHA_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data),
      "stalled result beat changed")
   `BHA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid,
      "result beat present after reset")
   `BHA_ASSERT(a_read_busy, clock, reset,
      req_valid && !req_stall && req_data.req_type == bha_pkg::REQ_READ |=> req_stall,
      "read beat did not occupy the block")
   `BHA_ASSERT(a_rsp_from_read, clock, reset, $rose(rsp_valid) |-> $past(req_stall),
      "result beat appeared without a read in progress")

endmodule

bind beat_histogram_accumulator bha_port_checker u_checker (.*);
